/* src/pnm_hp_pkg.sv */
// PNM header parser: shared types and constants.
// Used by the channel interfaces, the parse core and the top level.
package pnm_hp_pkg;

	localparam int FIELD_W = 16;

	// character codes
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// status codes
	localparam logic [1:0] ST_READING  = 2'd0;
	localparam logic [1:0] ST_FINISHED = 2'd1;
	localparam logic [1:0] ST_FAILED   = 2'd2;

	// image kinds
	localparam logic [1:0] KIND_BITMAP  = 2'd0;
	localparam logic [1:0] KIND_GRAYMAP = 2'd1;
	localparam logic [1:0] KIND_PIXMAP  = 2'd2;

	// bit positions in the fields-seen mask
	localparam int F_TYPE   = 0;
	localparam int F_ENC    = 1;
	localparam int F_WIDTH  = 2;
	localparam int F_HEIGHT = 3;
	localparam int F_MAX    = 4;
	localparam int F_NUM    = 5;

	typedef struct packed {
		logic [1:0]         status;
		logic [1:0]         image_kind;
		logic               raw_coding;
		logic [FIELD_W-1:0] image_width;
		logic [FIELD_W-1:0] image_height;
		logic [FIELD_W-1:0] max_level;
		logic [FIELD_W-1:0] header_length;
		logic               overflowed;
	} pnm_hp_info_t;

endpackage

/* src/pnm_hp_if.sv */
// PNM header parser: valid/ready channels for header bytes and parse results.
// Depends on pnm_hp_pkg.
interface pnm_hp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface pnm_hp_info_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic [1:0]                   image_kind;
	logic                         raw_coding;
	logic [pnm_hp_pkg::FIELD_W-1:0] image_width;
	logic [pnm_hp_pkg::FIELD_W-1:0] image_height;
	logic [pnm_hp_pkg::FIELD_W-1:0] max_level;
	logic [pnm_hp_pkg::FIELD_W-1:0] header_length;
	logic                         overflowed;

	modport source (output valid, output status, output image_kind, output raw_coding,
		output image_width, output image_height, output max_level,
		output header_length, output overflowed, input ready);
	modport sink (input valid, input status, input image_kind, input raw_coding,
		input image_width, input image_height, input max_level,
		input header_length, input overflowed, output ready);
endinterface

/* src/pnm_hp_core.sv */
// PNM header parser: parse state registers and the per-byte update logic.
// The state registers double as the result register. Depends on pnm_hp_pkg.
module pnm_hp_core #(
	parameter int NUM_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               data_byte,
	output pnm_hp_pkg::pnm_hp_info_t info
);
	import pnm_hp_pkg::*;

	localparam int WW = NUM_BITS + 4;

	typedef enum logic [2:0] {
		PH_NONE, PH_COMMENT, PH_WHITE, PH_TYPE, PH_WIDTH, PH_HEIGHT, PH_MAX
	} phase_t;

	typedef enum logic [1:0] {NUM_W, NUM_H, NUM_M} num_sel_t;

	phase_t              phase_q, phase_d;
	logic [F_NUM-1:0]    fields_q, fields_d;
	logic [1:0]          kind_q, kind_d;
	logic                raw_q, raw_d;
	logic [NUM_BITS-1:0] width_q, width_d;
	logic [NUM_BITS-1:0] height_q, height_d;
	logic [NUM_BITS-1:0] max_q, max_d;
	logic [NUM_BITS-1:0] offset_q, offset_d;
	logic                done_q, done_d;
	logic                err_q, err_d;
	logic                ovf_q, ovf_d;

	logic                is_ws, is_dig, type_ok;
	logic [1:0]          type_kind;
	logic                num_go, count_go;
	num_sel_t            num_sel;
	logic [NUM_BITS-1:0] acc_cur, acc_new;
	logic [WW-1:0]       acc_wide;
	logic                acc_sat;

	assign is_ws   = (data_byte == CH_SPACE) || (data_byte == CH_TAB) || (data_byte == CH_LF);
	assign is_dig  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign type_ok = (data_byte >= CH_ONE) && (data_byte <= CH_SIX);

	always_comb begin
		case (data_byte)
			CH_ONE, CH_FOUR:   type_kind = KIND_BITMAP;
			CH_TWO, CH_FIVE:   type_kind = KIND_GRAYMAP;
			CH_THREE, CH_SIX:  type_kind = KIND_PIXMAP;
			default:           type_kind = KIND_BITMAP;
		endcase
	end

	// acc * 10 + digit; the digit value is the low nibble of '0'..'9'
	always_comb begin
		case (num_sel)
			NUM_H:   acc_cur = height_q;
			NUM_M:   acc_cur = max_q;
			default: acc_cur = width_q;
		endcase
		acc_wide = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0}
			+ WW'(data_byte[3:0]);
		acc_sat  = |acc_wide[WW-1:NUM_BITS];
		acc_new  = acc_sat ? '1 : acc_wide[NUM_BITS-1:0];
	end

	always_comb begin
		phase_d  = phase_q;
		fields_d = fields_q;
		kind_d   = kind_q;
		raw_d    = raw_q;
		width_d  = width_q;
		height_d = height_q;
		max_d    = max_q;
		offset_d = offset_q;
		done_d   = done_q;
		err_d    = err_q;
		ovf_d    = ovf_q;
		num_go   = 1'b0;
		num_sel  = NUM_W;
		count_go = 1'b0;
		if (step && !done_q && !err_q) begin
			case (phase_q)
				PH_COMMENT: begin
					count_go = 1'b1;
					if (data_byte == CH_LF)
						phase_d = PH_WHITE;
				end
				PH_TYPE: begin
					if (type_ok) begin
						kind_d           = type_kind;
						raw_d            = (data_byte >= CH_FOUR);
						fields_d[F_TYPE] = 1'b1;
						fields_d[F_ENC]  = 1'b1;
						width_d          = '0;
						height_d         = '0;
						max_d            = '0;
						phase_d          = PH_WHITE;
						count_go         = 1'b1;
					end else begin
						err_d = 1'b1;
					end
				end
				PH_WIDTH: begin
					num_go  = 1'b1;
					num_sel = NUM_W;
				end
				PH_HEIGHT: begin
					num_go  = 1'b1;
					num_sel = NUM_H;
				end
				PH_MAX: begin
					num_go  = 1'b1;
					num_sel = NUM_M;
				end
				default: begin
					if (data_byte == CH_HASH) begin
						phase_d  = PH_COMMENT;
						count_go = 1'b1;
					end else if (is_ws) begin
						phase_d  = PH_WHITE;
						count_go = 1'b1;
					end else if (data_byte == CH_P) begin
						if (fields_q[F_TYPE]) begin
							err_d = 1'b1;
						end else begin
							phase_d  = PH_TYPE;
							count_go = 1'b1;
						end
					end else if (is_dig) begin
						if (!fields_q[F_TYPE]) begin
							err_d = 1'b1;
						end else begin
							num_go = 1'b1;
							if (fields_q[F_HEIGHT]) begin
								phase_d = PH_MAX;
								num_sel = NUM_M;
							end else if (fields_q[F_WIDTH]) begin
								phase_d = PH_HEIGHT;
								num_sel = NUM_H;
							end else begin
								phase_d = PH_WIDTH;
								num_sel = NUM_W;
							end
						end
					end else begin
						err_d = 1'b1;
					end
				end
			endcase

			if (num_go) begin
				if (is_dig) begin
					count_go = 1'b1;
					if (acc_sat)
						ovf_d = 1'b1;
					case (num_sel)
						NUM_H:   height_d = acc_new;
						NUM_M:   max_d = acc_new;
						default: width_d = acc_new;
					endcase
				end else if (is_ws) begin
					count_go = 1'b1;
					case (num_sel)
						NUM_H:   fields_d[F_HEIGHT] = 1'b1;
						NUM_M:   fields_d[F_MAX] = 1'b1;
						default: fields_d[F_WIDTH] = 1'b1;
					endcase
					// bitmaps carry no maxval
					if (num_sel == NUM_M || (num_sel == NUM_H && kind_q == KIND_BITMAP)) begin
						fields_d[F_MAX] = 1'b1;
						done_d          = 1'b1;
					end else begin
						phase_d = PH_WHITE;
					end
				end else begin
					err_d = 1'b1;
				end
			end

			if (count_go) begin
				if (&offset_q)
					ovf_d = 1'b1;
				else
					offset_d = offset_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_NONE;
			fields_q <= '0;
			kind_q   <= KIND_BITMAP;
			raw_q    <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
			max_q    <= '0;
			offset_q <= '0;
			done_q   <= 1'b0;
			err_q    <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			fields_q <= fields_d;
			kind_q   <= kind_d;
			raw_q    <= raw_d;
			width_q  <= width_d;
			height_q <= height_d;
			max_q    <= max_d;
			offset_q <= offset_d;
			done_q   <= done_d;
			err_q    <= err_d;
			ovf_q    <= ovf_d;
		end
	end

	assign info.status        = err_q ? ST_FAILED : (done_q ? ST_FINISHED : ST_READING);
	assign info.image_kind    = kind_q;
	assign info.raw_coding    = raw_q;
	assign info.image_width   = FIELD_W'(width_q);
	assign info.image_height  = FIELD_W'(height_q);
	assign info.max_level     = FIELD_W'(max_q);
	assign info.header_length = FIELD_W'(offset_q);
	assign info.overflowed    = ovf_q;

endmodule

/* src/pnm_header_parser.sv */
// PNM header parser. One header byte per transfer in, one result per byte out: status,
// image kind and coding, width, height, maxval, header length and overflow. A byte is
// registered in the input register, then the state update (a multiply-by-ten accumulate
// and a length increment) writes the result register, and the block takes one byte every
// clock while the result side keeps up. Finished and failed are sticky until reset;
// numbers and the length saturate at 2^NUM_BITS - 1, with the low 16 bits shown.
// Depends on pnm_hp_pkg, pnm_hp_if and pnm_hp_core.
module pnm_header_parser #(
	parameter int NUM_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pnm_hp_byte_if.sink          hdr_byte,
	pnm_hp_info_if.source        hdr_info
);
	import pnm_hp_pkg::*;

	logic         valid_s1, valid_s2;
	logic [7:0]   byte_s1;
	logic         adv_s2, step;
	pnm_hp_info_t info;

	assign adv_s2         = !valid_s2 || hdr_info.ready;
	assign hdr_byte.ready = !valid_s1 || adv_s2;
	assign step           = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (hdr_byte.ready)
				valid_s1 <= hdr_byte.valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_byte.valid && hdr_byte.ready)
			byte_s1 <= hdr_byte.data_byte;
	end

	pnm_hp_core #(.NUM_BITS(NUM_BITS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.info      (info)
	);

	assign hdr_info.valid         = valid_s2;
	assign hdr_info.status        = info.status;
	assign hdr_info.image_kind    = info.image_kind;
	assign hdr_info.raw_coding    = info.raw_coding;
	assign hdr_info.image_width   = info.image_width;
	assign hdr_info.image_height  = info.image_height;
	assign hdr_info.max_level     = info.max_level;
	assign hdr_info.header_length = info.header_length;
	assign hdr_info.overflowed    = info.overflowed;

endmodule

/* src/pnm_hp_checker.sv */
// PNM header parser: port-level checks, bound to the top level.
// Depends on pnm_hp_pkg and pnm_header_parser.
module pnm_hp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [1:0]                   status,
	input logic [pnm_hp_pkg::FIELD_W-1:0] header_length
);
	import pnm_hp_pkg::*;

	logic               seen_q;
	logic [1:0]         last_status_q;
	logic [FIELD_W-1:0] last_len_q;
	logic               xfer;

	assign xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= 1'b0;
			last_status_q <= ST_READING;
			last_len_q    <= '0;
		end else if (xfer) begin
			seen_q        <= 1'b1;
			last_status_q <= status;
			last_len_q    <= header_length;
		end
	end

	// length never shrinks from one result to the next
	a_len_grows: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && seen_q |-> header_length >= last_len_q)
		else $error("header length went backwards");

	// finished and failed stick, and the length freezes with them
	a_end_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && seen_q && last_status_q != ST_READING
		|-> status == last_status_q && header_length == last_len_q)
		else $error("terminal status did not hold");

	// a result never carries an unused status code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_READING || status == ST_FINISHED || status == ST_FAILED)
		else $error("unused status code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(header_length) && $stable(status))
		else $error("stalled result changed");

endmodule

bind pnm_header_parser pnm_hp_checker u_pnm_hp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (hdr_info.valid),
	.out_ready     (hdr_info.ready),
	.status        (hdr_info.status),
	.header_length (hdr_info.header_length)
);
